// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

   localparam int QueueDepth = 4;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       last;
   } item_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[idx];
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] h [8];
      h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
            32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide message intake, 64-round compression, eight-word digest output.
// A byte that completes a block holds the engine through load, rounds and add; a
// last byte adds padding, one or two compressions and eight digest output words.
// Throughput: one byte per cycle until the 4-entry queue, absorbing the wait, fills.
// Reset: synchronous; chaining state returns to the initial hash values.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher #(
   parameter int QueueDepth = sha_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   sha_pkg::item_type in_item, q_item;
   logic q_valid, q_take;

   assign in_item = '{msg_byte: req_msg_byte, byte_valid: req_byte_valid, last: req_last};

   sha_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_item,
      .out_valid(q_valid), .out_take(q_take), .out_item(q_item));

   sha_engine u_engine (
      .clock, .reset, .item_valid(q_valid), .item_take(q_take), .item(q_item),
      .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index, .rsp_last_word);
endmodule
`default_nettype wire

// ===== rtl/core/sha_queue.sv =====
// ----------------------------------------------------------------------------
// SHA input queue
// Small FIFO that parts byte intake from block processing.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_queue #(
   parameter int Depth = sha_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire sha_pkg::item_type in_item,
   output logic                  out_valid,
   input  wire logic             out_take,
   output sha_pkg::item_type     out_item
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   sha_pkg::item_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && out_take;

   always_comb begin
      wr_in  = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ===== rtl/core/sha_engine.sv =====
// ----------------------------------------------------------------------------
// SHA engine
// Buffers bytes, pads, runs one compression round per cycle, emits digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_take,
   input  wire sha_pkg::item_type item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [31:0]            rsp_digest_word,
   output logic [2:0]             rsp_word_index,
   output logic                   rsp_last_word
);
   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_EMIT
   } state_type;

   state_type     state_ff;
   logic [5:0]    fill_ff;
   logic [63:0]   bits_ff;
   logic [63:0]   total_ff;
   logic [31:0]   h_ff [8];
   logic [31:0]   v_ff [8];
   logic [31:0]   w_ff [16];
   logic [5:0]    rnd_ff;
   logic [5:0]    pos_ff;
   logic          final_ff;
   logic          fin_ff;
   logic [2:0]    idx_ff;

   logic [31:0] s1, ch, t1, s0, mj, t2, wn, wr, ws0, ws1;

   assign item_take       = (state_ff == S_IDLE) && item_valid;
   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   always_comb begin
      wr  = w_ff[0];
      ws0 = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      ws1 = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn  = ws1 + w_ff[9] + ws0 + w_ff[0];
      s1  = sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
          ^ sha_pkg::rotr(v_ff[4], 25);
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1  = v_ff[7] + s1 + ch + sha_pkg::round_k(rnd_ff) + wr;
      s0  = sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
          ^ sha_pkg::rotr(v_ff[0], 22);
      mj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2  = s0 + mj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         idx_ff   <= '0;
         rnd_ff   <= '0;
         final_ff <= 1'b0;
         fin_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::init_h(3'(i));
      end else begin
         case (state_ff)
            S_IDLE: if (item_valid) begin
               fin_ff <= item.last;
               total_ff <= bits_ff + {55'd0, fill_ff, 3'd0}
                           + (item.byte_valid ? 64'd8 : 64'd0);
               if (item.byte_valid) begin
                  w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= item.msg_byte;
                  fill_ff <= fill_ff + 1'b1;
                  if (fill_ff == 6'd63) begin
                     final_ff <= 1'b0;
                     bits_ff  <= bits_ff + 64'd512;
                     rnd_ff   <= '0;
                     pos_ff   <= '0;
                     state_ff <= S_LOAD;
                  end else if (item.last) begin
                     pos_ff   <= fill_ff + 1'b1;
                     state_ff <= S_PAD;
                  end
               end else if (item.last) begin
                  pos_ff   <= fill_ff;
                  state_ff <= S_PAD;
               end
            end
            S_PAD: begin
               // 0x80 at pos, zero the rest; length if room
               for (int b = 0; b < 64; b++) begin
                  if (b >= 56 && pos_ff < 6'd56)
                     w_ff[4'(b >> 2)][24 - 8*(b & 3) +: 8] <= total_ff[8*(63-b) +: 8];
                  else if (6'(b) == pos_ff)
                     w_ff[4'(b >> 2)][24 - 8*(b & 3) +: 8] <= 8'h80;
                  else if (6'(b) > pos_ff)
                     w_ff[4'(b >> 2)][24 - 8*(b & 3) +: 8] <= 8'h00;
               end
               final_ff <= (pos_ff < 6'd56);
               fill_ff  <= '0;
               rnd_ff   <= '0;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wn;
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff <= rnd_ff + 1'b1;
               if (rnd_ff == 6'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (final_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_EMIT;
               end else if (fin_ff) begin
                  fill_ff  <= '0;
                  rnd_ff   <= '0;
                  if (pos_ff == '0) begin
                     // block filled by last byte: pad fresh block
                     state_ff <= S_PAD;
                  end else begin
                     // second padding pass: zero block with length
                     for (int i = 0; i < 14; i++) w_ff[i] <= '0;
                     w_ff[14] <= total_ff[63:32];
                     w_ff[15] <= total_ff[31:0];
                     final_ff <= 1'b1;
                     state_ff <= S_LOAD;
                  end
               end else state_ff <= S_IDLE;
            end
            S_EMIT: if (!rsp_stall) begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::init_h(3'(i));
                  bits_ff  <= '0;
                  fill_ff  <= '0;
                  fin_ff   <= 1'b0;
                  final_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/sha_checker.sv =====
// ----------------------------------------------------------------------------
// SHA port checker
// Watches the result channel of the hasher.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7))) else $error("last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)) else $error("hold");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=>
      rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1) else $error("seq");
endmodule

bind sha256_stream_hasher sha_checker u_checker (.*);
`default_nettype wire
